// ----- hw/rtl/fscc_pkg.sv -----
package fscc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CountW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CountW-1:0] ClickSat = CountW'(3);
  localparam logic [CountW-1:0] ClickDouble = CountW'(2);

  localparam logic [CfgW-1:0] DoubleClickReset = CfgW'(300);
  localparam logic [CfgW-1:0] LongPressReset   = CfgW'(1000);

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegDoubleClick = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLongPress   = 1'b1;

  localparam logic [ModeW-1:0] ModeStandby = 2'd0;
  localparam logic [ModeW-1:0] ModeTuning  = 2'd1;

  localparam logic LevelPressed = 1'b0;
  localparam logic LevelOpen    = 1'b1;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvNormal = 2'd1,
    EvDouble = 2'd2,
    EvLong   = 2'd3
  } press_event_e;

  typedef struct packed {
    logic             level;
    logic [TimeW-1:0] time_ms;
    logic [ModeW-1:0] mode;
  } fscc_item_t;

  typedef struct packed {
    press_event_e event_code;
    logic         relay;
    logic         change;
    logic         new_mode;
  } fscc_res_t;

  typedef struct packed {
    logic [CfgW-1:0] double_click_ms;
    logic [CfgW-1:0] long_press_ms;
  } fscc_cfg_t;

endpackage

// ----- hw/rtl/fscc_cfg.sv -----
module fscc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [fscc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fscc_pkg::CfgW-1:0]       cfg_data_i,
  output fscc_pkg::fscc_cfg_t             cfg_o
);
  import fscc_pkg::*;

  logic [CfgW-1:0] double_click_q;
  logic [CfgW-1:0] long_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      double_click_q <= DoubleClickReset;
      long_press_q   <= LongPressReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDoubleClick: double_click_q <= cfg_data_i;
        RegLongPress:   long_press_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.double_click_ms = double_click_q;
  assign cfg_o.long_press_ms   = long_press_q;

endmodule

// ----- hw/rtl/fscc_core.sv -----
module fscc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  fscc_pkg::fscc_item_t item_i,
  input  fscc_pkg::fscc_cfg_t  cfg_i,
  output fscc_pkg::fscc_res_t  res_o
);
  import fscc_pkg::*;

  logic              last_level_q, last_level_d;
  logic [TimeW-1:0]  press_start_q, press_start_d;
  logic [TimeW-1:0]  prev_press_q, prev_press_d;
  logic [CountW-1:0] click_count_q, click_count_d;
  logic              long_fired_q, long_fired_d;
  logic              relay_q, relay_d;

  logic             press_edge;
  logic             release_edge;
  logic [TimeW-1:0] gap;
  logic [TimeW-1:0] held;
  logic             held_long;

  always_comb begin
    press_edge   = (item_i.level == LevelPressed) && (last_level_q == LevelOpen);
    release_edge = (item_i.level == LevelOpen) && (last_level_q == LevelPressed);
    gap          = item_i.time_ms - prev_press_q;

    last_level_d  = item_i.level;
    press_start_d = press_start_q;
    prev_press_d  = prev_press_q;
    click_count_d = click_count_q;
    long_fired_d  = long_fired_q;
    relay_d       = relay_q;

    res_o.event_code = EvNone;
    res_o.change     = 1'b0;
    res_o.new_mode   = 1'b0;

    if (press_edge) begin
      press_start_d = item_i.time_ms;
      prev_press_d  = item_i.time_ms;
      long_fired_d  = 1'b0;
      if (gap <= TimeW'(cfg_i.double_click_ms)) begin
        if (click_count_q != ClickSat) begin
          click_count_d = click_count_q + CountW'(1);
        end
      end else begin
        click_count_d = CountW'(1);
      end
    end

    // One subtractor serves both the hold check and the release check.
    held      = item_i.time_ms - press_start_d;
    held_long = held >= TimeW'(cfg_i.long_press_ms);

    if (item_i.level == LevelPressed) begin
      if (held_long && !long_fired_d) begin
        res_o.event_code = EvLong;
        long_fired_d     = 1'b1;
      end
    end

    if (release_edge && !long_fired_d) begin
      if (click_count_d == ClickDouble) begin
        res_o.event_code = EvDouble;
      end else if (!held_long) begin
        res_o.event_code = EvNormal;
        case (item_i.mode)
          ModeStandby: begin
            relay_d        = 1'b1;
            res_o.change   = 1'b1;
            res_o.new_mode = 1'b1;
          end
          ModeTuning: begin
            relay_d      = 1'b0;
            res_o.change = 1'b1;
          end
          default: ;
        endcase
      end
    end

    res_o.relay = relay_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q  <= LevelOpen;
      press_start_q <= '0;
      prev_press_q  <= '0;
      click_count_q <= '0;
      long_fired_q  <= 1'b0;
      relay_q       <= 1'b0;
    end else if (step_i) begin
      last_level_q  <= last_level_d;
      press_start_q <= press_start_d;
      prev_press_q  <= prev_press_d;
      click_count_q <= click_count_d;
      long_fired_q  <= long_fired_d;
      relay_q       <= relay_d;
    end
  end

endmodule

// ----- hw/rtl/footswitch_click_classifier.sv -----
// Footswitch click classifier.
//
// Input channel: one request per poll carries switch_level_i (0 pressed),
// time_ms_i and tuner_mode_i. It is accepted on a rising edge where
// in_valid_i is high and in_stall_o is low.
// Output channel: one result per poll with press_event_o, relay_level_o,
// mode_change_o and new_mode_o, taken when out_valid_o is high and
// out_stall_i is low.
// The poll lands in an input register, and the classification against the
// switch state registers is written into the result register. Throughput is
// one poll per cycle while out_stall_i does not hold the result register.
// When the receiver stalls, the result register holds, and the input
// register keeps taking one more poll before in_stall_o rises.
// Configuration writes (index 0 double-click window, index 1 long-press
// time) are always ready and should be issued only while the block is idle.
// Reset clears the switch state to open with the relay off, and loads the
// default timings of 300 ms and 1000 ms.
module footswitch_click_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          switch_level_i,
  input  logic [fscc_pkg::TimeW-1:0]    time_ms_i,
  input  logic [fscc_pkg::ModeW-1:0]    tuner_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    press_event_o,
  output logic                          relay_level_o,
  output logic                          mode_change_o,
  output logic                          new_mode_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fscc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fscc_pkg::CfgW-1:0]     cfg_data_i
);
  import fscc_pkg::*;

  fscc_cfg_t  cfg;
  fscc_item_t item_q;
  logic       item_valid_q;
  fscc_res_t  res;
  fscc_res_t  res_q;
  logic       res_valid_q;

  logic out_free;
  logic step;
  logic in_take;

  assign cfg_ready_o = 1'b1;

  fscc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free   = !res_valid_q || !out_stall_i;
  assign step       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  fscc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (step) begin
        item_valid_q <= 1'b0;
      end
      if (out_free) begin
        res_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.level   <= switch_level_i;
      item_q.time_ms <= time_ms_i;
      item_q.mode    <= tuner_mode_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = res_valid_q;
  assign press_event_o = res_q.event_code;
  assign relay_level_o = res_q.relay;
  assign mode_change_o = res_q.change;
  assign new_mode_o    = res_q.new_mode;

  // A mode request comes only with a normal press.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_change_o |-> press_event_o == EvNormal)
    else $error("mode change without a normal press");

  // Without a mode request the requested mode reads as standby.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_change_o |-> !new_mode_o)
    else $error("new mode set without a mode change");

  // The input side only backs up when a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && item_valid_q)
    else $error("input stalled while the result register is free");

endmodule
